[hdl/bma_pkg.sv]
// ---------------------------------------------------------------------------
// bma_pkg - bus mouse adapter definitions
// operation and port codes, command selectors, control bytes and helpers
// ---------------------------------------------------------------------------
package bma_pkg;

    // item kinds carried in tuser
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_MOVE  = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    // port offsets
    typedef enum logic [1:0] {
        PORT_CONTROL   = 2'd0,
        PORT_DATA      = 2'd1,
        PORT_SIGNATURE = 2'd2,
        PORT_UNUSED    = 2'd3
    } port_t;

    // data port selectors
    localparam logic [2:0] CMD_BUTTONS = 3'd0;
    localparam logic [2:0] CMD_X       = 3'd1;
    localparam logic [2:0] CMD_Y       = 3'd2;
    localparam logic [2:0] CMD_COMMAND = 3'd7;

    // fixed byte values and the interrupt keep bit index
    localparam logic [7:0] SIG_FIRST    = 8'hDE;
    localparam logic [7:0] SIG_SECOND   = 8'h22;
    localparam logic [7:0] CMD_IRQ_OFF  = 8'h10;
    localparam logic [7:0] CMD_IRQ_ON   = 8'h11;
    localparam int         KEEP_IRQ_BIT = 5;
    localparam logic [7:0] CTRL_RESET   = 8'h80;

    localparam logic [7:0] BYTE_MAX = 8'h7F;
    localparam logic [7:0] BYTE_MIN = 8'h80;

    // halve toward zero when magnitude exceeds one, clamp to a signed byte
    function automatic logic signed [7:0] scale_delta(input logic signed [15:0] d);
        logic signed [15:0] h;
        begin
            h = d;
            if (d < -16'sd1 || d > 16'sd1) begin
                h = d + $signed({15'd0, d[15]});
                h = h >>> 1;
            end
            if (h > 16'sd127) begin
                scale_delta = $signed(BYTE_MAX);
            end else if (h < -16'sd128) begin
                scale_delta = $signed(BYTE_MIN);
            end else begin
                scale_delta = h[7:0];
            end
        end
    endfunction

    // saturate a 17-bit sum to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        begin
            if (v > 17'sd32767) begin
                sat16 = 16'sh7FFF;
            end else if (v < -17'sd32768) begin
                sat16 = 16'sh8000;
            end else begin
                sat16 = v[15:0];
            end
        end
    endfunction

endpackage

[hdl/bus_mouse_adapter.sv]
// ---------------------------------------------------------------------------
// bus_mouse_adapter - four-port bus mouse adapter
// port reads and writes, motion events and timer ticks, one result per item
// ---------------------------------------------------------------------------
//
//  channel  | direction | tdata (low bit up)                          | tuser
//  ---------+-----------+---------------------------------------------+----------
//  s_       | in        | port, write_data, move_x, move_y, buttons   | operation
//  m_       | out       | read_data, irq_level, access_error          | -
//
//  one word per cycle sustained while results are taken; each word passes
//  through the input register and then leaves through the result register
//  state is updated as the word moves from input register to result register
//  aresetn (synchronous, active low) clears all adapter state and both valids
//  a stalled result holds; the input register still takes a word while the
//  result waits, and s_tready drops only when both stages are full
//
module bus_mouse_adapter
    import bma_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // port[1:0], write_data[9:2], move_x[25:10], move_y[41:26], buttons[44:42]
    input  logic [47:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], irq_level[8], access_error[9]
    output logic [15:0] m_tdata
);

    // input register
    logic               in_valid_reg;
    logic [1:0]         op_reg;
    logic [1:0]         port_reg;
    logic [7:0]         wdata_reg;
    logic signed [15:0] move_x_reg;
    logic signed [15:0] move_y_reg;
    logic [2:0]         buttons_reg;

    // result register
    logic               out_valid_reg;
    logic [7:0]         rdata_reg;
    logic               irq_out_reg;
    logic               err_reg;

    // adapter state
    logic [7:0]         control_reg,  control_next;
    logic [2:0]         sel_cmd_reg,  sel_cmd_next;
    logic [7:0]         cmd_byte_reg, cmd_byte_next;
    logic               irq_en_reg,   irq_en_next;
    logic               irq_line_reg, irq_line_next;
    logic               sig_phase_reg, sig_phase_next;
    logic [7:0]         lat_x_reg,    lat_x_next;
    logic [7:0]         lat_y_reg,    lat_y_next;
    logic [7:0]         lat_btn_reg,  lat_btn_next;
    logic signed [15:0] carry_x_reg,  carry_x_next;
    logic signed [15:0] carry_y_reg,  carry_y_next;

    logic               advance;
    logic [7:0]         rdata_next;
    logic               err_next;

    // motion path
    logic signed [7:0]  dx;
    logic signed [7:0]  dy;
    logic signed [15:0] cx;
    logic signed [15:0] cy;

    // result stage free or draining this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, err_reg, irq_out_reg, rdata_reg};

    // scaled deltas and saturated carries
    assign dx = scale_delta(move_x_reg);
    assign dy = scale_delta(move_y_reg);
    assign cx = sat16($signed({carry_x_reg[15], carry_x_reg})
                      + $signed({{9{dx[7]}}, dx}));
    assign cy = sat16($signed({carry_y_reg[15], carry_y_reg})
                      - $signed({{9{dy[7]}}, dy}));

    always_comb begin
        control_next   = control_reg;
        sel_cmd_next   = sel_cmd_reg;
        cmd_byte_next  = cmd_byte_reg;
        irq_en_next    = irq_en_reg;
        irq_line_next  = irq_line_reg;
        sig_phase_next = sig_phase_reg;
        lat_x_next     = lat_x_reg;
        lat_y_next     = lat_y_reg;
        lat_btn_next   = lat_btn_reg;
        carry_x_next   = carry_x_reg;
        carry_y_next   = carry_y_reg;
        rdata_next     = 8'd0;
        err_next       = 1'b0;

        case (op_t'(op_reg))
            OP_READ: begin
                case (port_t'(port_reg))
                    PORT_CONTROL: rdata_next = control_reg;
                    PORT_DATA: begin
                        case (sel_cmd_reg)
                            CMD_BUTTONS: rdata_next = lat_btn_reg;
                            CMD_X:       rdata_next = lat_x_reg;
                            CMD_Y:       rdata_next = lat_y_reg;
                            CMD_COMMAND: rdata_next = cmd_byte_reg;
                            default:     err_next   = 1'b1;
                        endcase
                    end
                    PORT_SIGNATURE: begin
                        rdata_next     = sig_phase_reg ? SIG_SECOND : SIG_FIRST;
                        sig_phase_next = !sig_phase_reg;
                    end
                    default: err_next = 1'b1;
                endcase
            end
            OP_WRITE: begin
                case (port_t'(port_reg))
                    PORT_CONTROL: begin
                        control_next = wdata_reg;
                        // restored command decode
                        if (wdata_reg == {5'd0, CMD_BUTTONS} || wdata_reg == {5'd0, CMD_X}
                            || wdata_reg == {5'd0, CMD_Y}
                            || wdata_reg == {5'd0, CMD_COMMAND}) begin
                            sel_cmd_next = wdata_reg[2:0];
                        end else if (wdata_reg == CTRL_RESET) begin
                            sel_cmd_next  = CMD_BUTTONS;
                            cmd_byte_next = CTRL_RESET;
                        end
                    end
                    PORT_DATA: begin
                        if (sel_cmd_reg == CMD_COMMAND) begin
                            if (wdata_reg == CMD_IRQ_OFF) begin
                                irq_en_next = 1'b0;
                            end else if (wdata_reg == CMD_IRQ_ON) begin
                                irq_en_next = 1'b1;
                            end else begin
                                cmd_byte_next = wdata_reg;
                                if (!wdata_reg[KEEP_IRQ_BIT]) begin
                                    irq_line_next = 1'b0;
                                end
                            end
                        end else begin
                            err_next = 1'b1;
                        end
                    end
                    default: err_next = 1'b1;
                endcase
            end
            OP_MOVE: begin
                // emit at most a signed byte from each carry, keep the rest
                if (cx > 16'sd127) begin
                    lat_x_next   = BYTE_MAX;
                    carry_x_next = cx - 16'sd127;
                end else if (cx < -16'sd128) begin
                    lat_x_next   = BYTE_MIN;
                    carry_x_next = cx + 16'sd128;
                end else begin
                    lat_x_next   = cx[7:0];
                    carry_x_next = 16'sd0;
                end
                if (cy > 16'sd127) begin
                    lat_y_next   = BYTE_MAX;
                    carry_y_next = cy - 16'sd127;
                end else if (cy < -16'sd128) begin
                    lat_y_next   = BYTE_MIN;
                    carry_y_next = cy + 16'sd128;
                end else begin
                    lat_y_next   = cy[7:0];
                    carry_y_next = 16'sd0;
                end
                // inverted, left moved to bit 2 and right to bit 0
                lat_btn_next = ~{5'd0, buttons_reg[0], 1'b0, buttons_reg[1]};
            end
            OP_TICK: begin
                if (irq_en_reg) begin
                    irq_line_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            op_reg      <= s_tuser[1:0];
            port_reg    <= s_tdata[1:0];
            wdata_reg   <= s_tdata[9:2];
            move_x_reg  <= s_tdata[25:10];
            move_y_reg  <= s_tdata[41:26];
            buttons_reg <= s_tdata[44:42];
        end
    end

    // state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            control_reg   <= 8'd0;
            sel_cmd_reg   <= CMD_BUTTONS;
            cmd_byte_reg  <= 8'd0;
            irq_en_reg    <= 1'b0;
            irq_line_reg  <= 1'b0;
            sig_phase_reg <= 1'b0;
            lat_x_reg     <= 8'd0;
            lat_y_reg     <= 8'd0;
            lat_btn_reg   <= 8'd0;
            carry_x_reg   <= 16'sd0;
            carry_y_reg   <= 16'sd0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                control_reg   <= control_next;
                sel_cmd_reg   <= sel_cmd_next;
                cmd_byte_reg  <= cmd_byte_next;
                irq_en_reg    <= irq_en_next;
                irq_line_reg  <= irq_line_next;
                sig_phase_reg <= sig_phase_next;
                lat_x_reg     <= lat_x_next;
                lat_y_reg     <= lat_y_next;
                lat_btn_reg   <= lat_btn_next;
                carry_x_reg   <= carry_x_next;
                carry_y_reg   <= carry_y_next;
            end
        end
        if (advance && in_valid_reg) begin
            rdata_reg   <= rdata_next;
            irq_out_reg <= irq_line_next;
            err_reg     <= err_next;
        end
    end

endmodule

[verif/tb_bus_mouse_adapter.sv]
// ---------------------------------------------------------------------------
// tb_bus_mouse_adapter - self-checking bench for the bus mouse adapter
// a queue of port accesses, motion events and ticks is streamed in with
// random gaps; every reply word is checked field by field against an
// in-bench copy of the adapter registers and motion carries
// ---------------------------------------------------------------------------
module tb_bus_mouse_adapter;
    timeunit 1ns;
    timeprecision 1ps;

    import bma_pkg::*;

    // one input word, fields as packed into s_tdata / s_tuser
    typedef struct packed {
        op_t                op;
        port_t              port;
        logic [7:0]         wdata;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [2:0]         buttons;
    } mouse_req_t;

    // one reply word
    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_level;
        logic       access_error;
    } adapter_reply_t;

    localparam int RANDOM_WORDS = 1450;
    // no gaps on either side while this many words have gone through
    localparam int CALM_FROM    = 600;
    localparam int CALM_TO      = 900;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    bus_mouse_adapter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // mirror of the adapter registers, all cleared as after reset
    // -----------------------------------------------------------------------
    logic [7:0] ctrl_reg    = '0;
    logic [2:0] sel_cmd     = CMD_BUTTONS;
    logic [7:0] cmd_reg     = '0;
    logic       irq_en      = 1'b0;
    logic       irq_line    = 1'b0;
    logic       sig_phase   = 1'b0;
    logic [7:0] lat_x       = '0;
    logic [7:0] lat_y       = '0;
    logic [7:0] lat_buttons = '0;
    int         carry_x     = 0;
    int         carry_y     = 0;

    mouse_req_t     pending_reqs[$];
    adapter_reply_t awaited_replies[$];
    mouse_req_t     on_bus;

    int total_words  = 0;
    int sent_words   = 0;
    int replies_seen = 0;
    int mismatches   = 0;
    int op_seen[4]   = '{default: 0};
    int err_seen     = 0;
    int irq_high     = 0;

    function automatic int clip(input int v, input int lo, input int hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // deltas of magnitude two or more are halved, rounding toward zero
    function automatic int halve_toward_zero(input int d);
        return (d > 1 || d < -1) ? d / 2 : d;
    endfunction

    // applies one word to the mirrored registers and gives the reply it earns
    task automatic compute_adapter_reply(input mouse_req_t rq, output adapter_reply_t rp);
        int step_x;
        int step_y;
        int out_x;
        int out_y;
        rp = '0;
        case (rq.op)
            OP_READ: begin
                case (rq.port)
                    PORT_CONTROL: rp.read_data = ctrl_reg;
                    PORT_DATA: begin
                        case (sel_cmd)
                            CMD_BUTTONS: rp.read_data = lat_buttons;
                            CMD_X:       rp.read_data = lat_x;
                            CMD_Y:       rp.read_data = lat_y;
                            CMD_COMMAND: rp.read_data = cmd_reg;
                            default:     rp.access_error = 1'b1;
                        endcase
                    end
                    PORT_SIGNATURE: begin
                        rp.read_data = sig_phase ? SIG_SECOND : SIG_FIRST;
                        sig_phase = ~sig_phase;
                    end
                    default: rp.access_error = 1'b1;
                endcase
            end
            OP_WRITE: begin
                case (rq.port)
                    PORT_CONTROL: begin
                        // the byte is always stored, only known values decode
                        ctrl_reg = rq.wdata;
                        if (rq.wdata inside {CMD_BUTTONS, CMD_X, CMD_Y, CMD_COMMAND}) begin
                            sel_cmd = rq.wdata[2:0];
                        end else if (rq.wdata == CTRL_RESET) begin
                            sel_cmd = CMD_BUTTONS;
                            cmd_reg = CTRL_RESET;
                        end
                    end
                    PORT_DATA: begin
                        if (sel_cmd != CMD_COMMAND) begin
                            rp.access_error = 1'b1;
                        end else if (rq.wdata == CMD_IRQ_OFF) begin
                            irq_en = 1'b0;
                        end else if (rq.wdata == CMD_IRQ_ON) begin
                            irq_en = 1'b1;
                        end else begin
                            cmd_reg = rq.wdata;
                            if (!rq.wdata[KEEP_IRQ_BIT]) irq_line = 1'b0;
                        end
                    end
                    default: rp.access_error = 1'b1;
                endcase
            end
            OP_MOVE: begin
                step_x  = clip(halve_toward_zero(rq.dx), -128, 127);
                step_y  = clip(halve_toward_zero(rq.dy), -128, 127);
                // y counts upward on the bus, hence the subtraction
                carry_x = clip(carry_x + step_x, -32768, 32767);
                carry_y = clip(carry_y - step_y, -32768, 32767);
                // a byte's worth leaves, the rest stays in the carry
                out_x   = clip(carry_x, -128, 127);
                out_y   = clip(carry_y, -128, 127);
                carry_x -= out_x;
                carry_y -= out_y;
                lat_x   = out_x[7:0];
                lat_y   = out_y[7:0];
                // left lands on bit 2, right on bit 0, then inverted
                lat_buttons = ~{5'b00000, rq.buttons[0], 1'b0, rq.buttons[1]};
            end
            default: begin
                if (irq_en) irq_line = 1'b1;
            end
        endcase
        rp.irq_level = irq_line;
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("reply %0d: %s", replies_seen, msg);
    endtask

    // register access, motion fields filled with noise
    task automatic push_access(input op_t op, input port_t port, input logic [7:0] wdata);
        mouse_req_t rq;
        rq.op      = op;
        rq.port    = port;
        rq.wdata   = wdata;
        rq.dx      = 16'($urandom);
        rq.dy      = 16'($urandom);
        rq.buttons = 3'($urandom);
        pending_reqs.push_back(rq);
    endtask

    // motion event, port and write byte filled with noise
    task automatic push_move(input logic signed [15:0] dx, input logic signed [15:0] dy,
                             input logic [2:0] buttons);
        mouse_req_t rq;
        rq.op      = OP_MOVE;
        rq.port    = port_t'($urandom_range(3));
        rq.wdata   = 8'($urandom);
        rq.dx      = dx;
        rq.dy      = dy;
        rq.buttons = buttons;
        pending_reqs.push_back(rq);
    endtask

    // small hand movements, fast ones, and in half the cases anything at all
    function automatic logic signed [15:0] pick_delta();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(6) - 3);
            1:       return 16'($urandom_range(800) - 400);
            default: return 16'($urandom);
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // driver: offers words from the pending queue, predicts each one taken
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        mouse_req_t     nxt;
        adapter_reply_t want;
        logic           gap;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                compute_adapter_reply(on_bus, want);
                awaited_replies.push_back(want);
                op_seen[on_bus.op]++;
                sent_words++;
            end
            if (!s_tvalid || s_tready) begin
                gap = (sent_words >= CALM_FROM && sent_words < CALM_TO) ? 1'b0 :
                      ($urandom_range(99) < 16);
                if (pending_reqs.size() != 0 && !gap) begin
                    nxt      = pending_reqs.pop_front();
                    on_bus   = nxt;
                    s_tdata  <= {3'b000, nxt.buttons, nxt.dy, nxt.dx, nxt.wdata, nxt.port};
                    s_tuser  <= nxt.op;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // monitor: random back-pressure, every reply checked in order
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        adapter_reply_t got;
        adapter_reply_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.read_data    = m_tdata[7:0];
                got.irq_level    = m_tdata[8];
                got.access_error = m_tdata[9];
                if (awaited_replies.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %04h", m_tdata));
                end else begin
                    want = awaited_replies.pop_front();
                    if (got.read_data !== want.read_data)
                        report_mismatch($sformatf("read_data %02h, expected %02h",
                                                  got.read_data, want.read_data));
                    if (got.irq_level !== want.irq_level)
                        report_mismatch($sformatf("irq_level %b, expected %b",
                                                  got.irq_level, want.irq_level));
                    if (got.access_error !== want.access_error)
                        report_mismatch($sformatf("access_error %b, expected %b",
                                                  got.access_error, want.access_error));
                end
                if (got.access_error === 1'b1) err_seen++;
                if (got.irq_level === 1'b1) irq_high++;
                replies_seen++;
            end
            if (replies_seen >= CALM_FROM && replies_seen < CALM_TO) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 16);
            end
        end
    end

    // -----------------------------------------------------------------------
    // stimulus and end of run
    // -----------------------------------------------------------------------
    initial begin
        mouse_req_t rq;
        int         target;
        int         n;

        // registers straight out of reset, signature both ways
        push_access(OP_READ,  PORT_CONTROL,   8'h00);
        push_access(OP_READ,  PORT_DATA,      8'h00);
        push_access(OP_READ,  PORT_SIGNATURE, 8'h00);
        push_access(OP_READ,  PORT_SIGNATURE, 8'hFF);
        // unused port, writes to read-only ports, data write outside command mode
        push_access(OP_READ,  PORT_UNUSED,    8'h00);
        push_access(OP_WRITE, PORT_SIGNATURE, 8'hFF);
        push_access(OP_WRITE, PORT_UNUSED,    8'h00);
        push_access(OP_WRITE, PORT_DATA,      CMD_IRQ_ON);
        // control byte that decodes to nothing
        push_access(OP_WRITE, PORT_CONTROL,   8'h55);
        // command mode: interrupt on, tick, acknowledge with and without the keep bit
        push_access(OP_WRITE, PORT_CONTROL,   CMD_COMMAND);
        push_access(OP_WRITE, PORT_DATA,      CMD_IRQ_ON);
        push_access(OP_TICK,  PORT_CONTROL,   8'h00);
        push_access(OP_WRITE, PORT_DATA,      8'hFF);
        push_access(OP_READ,  PORT_DATA,      8'h00);
        push_access(OP_WRITE, PORT_DATA,      8'h00);
        // tick with interrupts off leaves the line alone
        push_access(OP_WRITE, PORT_DATA,      CMD_IRQ_OFF);
        push_access(OP_TICK,  PORT_UNUSED,    8'hFF);
        // control reset, then motion at the field extremes
        push_access(OP_WRITE, PORT_CONTROL,   CTRL_RESET);
        push_access(OP_READ,  PORT_CONTROL,   8'h00);
        push_move(16'sh7FFF, 16'sh8000, 3'b111);
        push_move(16'sh8000, 16'sh7FFF, 3'b000);
        push_move(16'sd1, -16'sd1, 3'b101);
        push_move(-16'sd2, 16'sd3, 3'b010);
        push_access(OP_WRITE, PORT_CONTROL,   CMD_X);
        push_access(OP_READ,  PORT_DATA,      8'h00);
        push_access(OP_WRITE, PORT_CONTROL,   CMD_Y);
        push_access(OP_READ,  PORT_DATA,      8'h00);

        target = pending_reqs.size() + RANDOM_WORDS;
        while (pending_reqs.size() < target) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    // a few motion events, then fetch buttons, x or y
                    n = $urandom_range(1, 4);
                    repeat (n) push_move(pick_delta(), pick_delta(), 3'($urandom));
                    push_access(OP_WRITE, PORT_CONTROL, 8'($urandom_range(CMD_Y)));
                    repeat ($urandom_range(1, 2))
                        push_access(OP_READ, PORT_DATA, 8'($urandom));
                end
                3, 4: begin
                    // interrupt session in command mode
                    push_access(OP_WRITE, PORT_CONTROL, CMD_COMMAND);
                    if ($urandom_range(3) != 0)
                        push_access(OP_WRITE, PORT_DATA,
                                    ($urandom_range(3) != 0) ? CMD_IRQ_ON : CMD_IRQ_OFF);
                    repeat ($urandom_range(3)) push_access(OP_TICK, port_t'($urandom_range(3)),
                                                           8'($urandom));
                    push_access(OP_READ,  PORT_DATA, 8'($urandom));
                    push_access(OP_WRITE, PORT_DATA, 8'($urandom));
                    push_access(OP_READ,  PORT_CONTROL, 8'($urandom));
                end
                5: begin
                    // probing the signature and control ports
                    repeat ($urandom_range(1, 3))
                        push_access(OP_READ, PORT_SIGNATURE, 8'($urandom));
                    push_access(OP_WRITE, PORT_CONTROL,
                                ($urandom_range(1) != 0) ? CTRL_RESET : 8'($urandom));
                    push_access(OP_READ, PORT_CONTROL, 8'($urandom));
                end
                6: begin
                    // data write while a read command is selected
                    push_access(OP_WRITE, PORT_CONTROL, 8'($urandom_range(CMD_Y)));
                    push_access(OP_WRITE, PORT_DATA, 8'($urandom));
                end
                default: begin
                    // anything at all
                    repeat ($urandom_range(1, 3)) begin
                        rq.op      = op_t'($urandom_range(3));
                        rq.port    = port_t'($urandom_range(3));
                        rq.wdata   = 8'($urandom);
                        rq.dx      = 16'($urandom);
                        rq.dy      = 16'($urandom);
                        rq.buttons = 3'($urandom);
                        pending_reqs.push_back(rq);
                    end
                end
            endcase
        end
        total_words = pending_reqs.size();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        wait (sent_words == total_words);
        while (awaited_replies.size() != 0) @(posedge aclk);
        // two-stage pipe, a spare wait at the end catches any stray word
        repeat (8) @(posedge aclk);

        $display("%0d words: %0d reads, %0d writes, %0d motion events, %0d ticks",
                 sent_words, op_seen[OP_READ], op_seen[OP_WRITE], op_seen[OP_MOVE],
                 op_seen[OP_TICK]);
        $display("%0d replies checked, %0d access errors, interrupt line high in %0d",
                 replies_seen, err_seen, irq_high);
        if (mismatches == 0) begin
            $display("bus_mouse_adapter test passed");
        end else begin
            $display("bus_mouse_adapter test failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("bus_mouse_adapter test failed");
        $finish;
    end

endmodule
